// ----- rtl/pwook_pkg.sv -----
package pwook_pkg;

  // Message store geometry
  localparam int unsigned MaxBits = 64;
  localparam int unsigned LenW    = 7;
  localparam int unsigned TimeW   = 20;
  localparam int unsigned CfgIdxW = 3;

  // Operation codes carried in the input tuser
  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRepeatCount  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIntroTime    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegZeroLowTime  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegZeroHighTime = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOneLowTime   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOneHighTime  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFooterTime   = 3'd6;

  typedef enum logic [4:0] {
    PhIdle    = 5'b00001,
    PhIntro   = 5'b00010,
    PhBitLow  = 5'b00100,
    PhBitHigh = 5'b01000,
    PhFooter  = 5'b10000
  } phase_e;

  // Outcome of looking for the next bit that spends at least one tick
  typedef struct packed {
    logic               found;
    logic               bit_val;
    logic [MaxBits-1:0] rem_next;
  } srch_t;

  // Lowest set bit of (rem & live) wins; the bits up to and including it
  // are dropped from the remaining mask.
  function automatic srch_t bit_search(logic [MaxBits-1:0] rem,
                                       logic [MaxBits-1:0] live,
                                       logic [MaxBits-1:0] msg);
    logic [MaxBits-1:0] cand;
    logic [MaxBits-1:0] cand_m1;
    srch_t              r;
    cand       = rem & live;
    cand_m1    = cand - MaxBits'(1);
    r.found    = |cand;
    r.bit_val  = |(cand & ~cand_m1 & msg);
    r.rem_next = rem & ~(cand ^ cand_m1);
    return r;
  endfunction

  // Thermometer mask with the low len bits set
  function automatic logic [MaxBits-1:0] len_mask(logic [LenW-1:0] len);
    logic [MaxBits:0] t;
    t = ((MaxBits+1)'(1) << len) - (MaxBits+1)'(1);
    return t[MaxBits-1:0];
  endfunction

endpackage

// ----- rtl/pulse_width_ook_transmitter.sv -----
// Channel  | Direction | Handshake                     | Payload
// ---------+-----------+-------------------------------+---------------------------------
// s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata: message_bits, message_length
//          |           |                               | tuser: operation
// m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: line_level, busy_res, done_res
// cfg      | in        | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One item per cycle unless the result is stalled, result in the cycle after
// acceptance: each item (tick or start) is settled in that cycle, and runs of
// zero-length phases are skipped in one step by a search over the remaining-bits mask.
// A single result register: s_axis_tready is low only while it holds an item
// and m_axis_tready is low. cfg writes are always taken.
// Reset (rst_ni low, async) clears the configuration and leaves the line idle.
module pulse_width_ook_transmitter
  import pwook_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [71:0]         s_axis_tdata,  // [63:0] message_bits, [70:64] message_length
  input  logic [0:0]          s_axis_tuser,  // [0] operation
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // [0] line_level, [1] busy_res, [2] done_res
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [TimeW-1:0]    cfg_data_i
);

  // Configuration registers
  logic [7:0]       repeat_count_q;
  logic [15:0]      intro_time_q, zero_low_q, zero_high_q, one_low_q, one_high_q;
  logic [TimeW-1:0] footer_time_q;

  // Transmit state
  phase_e             phase_q, phase_d;
  logic [TimeW-1:0]   time_q, time_d;
  logic [7:0]         rep_q, rep_d;
  logic               cur_q, cur_d;        // value of the bit being sent
  logic [MaxBits-1:0] rem_q, rem_d;        // bits of this frame not yet visited
  logic [MaxBits-1:0] saved_msg_q, saved_msg_d;
  logic [LenW-1:0]    saved_len_q, saved_len_d;

  // Result register
  logic       out_valid_q;
  logic [2:0] out_data_q;

  logic in_fire;
  logic is_start;
  logic [MaxBits-1:0] in_msg;
  logic [LenW-1:0]    in_len, len_sat;
  logic [MaxBits-1:0] msg_sel, full_mask, live;
  logic [LenW-1:0]    len_sel;
  logic               zero_live, one_live;
  srch_t              sr_frame, sr_rem;

  // Frame-start outcome
  phase_e             fs_phase;
  logic [TimeW-1:0]   fs_time;
  logic               fs_cur;
  logic [MaxBits-1:0] fs_rem;

  // Outcome of entering the next bit low phase
  phase_e             be_phase;
  logic [TimeW-1:0]   be_time;
  logic               be_cur;
  logic [MaxBits-1:0] be_rem;
  logic [7:0]         be_rep;

  logic lvl, busy, done;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_start      = (s_axis_tuser[0] == OpStart);

  assign in_msg  = s_axis_tdata[63:0];
  assign in_len  = s_axis_tdata[70:64];
  assign len_sat = (in_len > LenW'(MaxBits)) ? LenW'(MaxBits) : in_len;

  // A start reads the message straight off the bus, ticks read the saved one
  assign msg_sel   = is_start ? in_msg : saved_msg_q;
  assign len_sel   = is_start ? len_sat : saved_len_q;
  assign full_mask = len_mask(len_sel);

  // A bit spends time only if one of its two phases is nonzero
  assign zero_live = (zero_low_q != 16'd0) || (zero_high_q != 16'd0);
  assign one_live  = (one_low_q != 16'd0) || (one_high_q != 16'd0);
  assign live      = (msg_sel & {MaxBits{one_live}}) | (~msg_sel & {MaxBits{zero_live}});

  assign sr_frame = bit_search(full_mask, live, msg_sel);
  assign sr_rem   = bit_search(rem_q, live, saved_msg_q);

  // First nonzero phase of a fresh frame; PhIdle when the frame is empty
  always_comb begin
    fs_phase = PhIdle;
    fs_time  = '0;
    fs_cur   = sr_frame.bit_val;
    fs_rem   = full_mask;
    if (intro_time_q != 16'd0) begin
      fs_phase = PhIntro;
      fs_time  = TimeW'(intro_time_q);
    end else if (sr_frame.found) begin
      fs_rem = sr_frame.rem_next;
      if ((sr_frame.bit_val ? one_low_q : zero_low_q) != 16'd0) begin
        fs_phase = PhBitLow;
        fs_time  = TimeW'(sr_frame.bit_val ? one_low_q : zero_low_q);
      end else begin
        fs_phase = PhBitHigh;
        fs_time  = TimeW'(sr_frame.bit_val ? one_high_q : zero_high_q);
      end
    end else if (footer_time_q != '0) begin
      fs_phase = PhFooter;
      fs_time  = footer_time_q;
    end
  end

  // Next bit, else footer; a zero footer closes the frame at once and the
  // next frame (known not empty here) starts in the same step.
  always_comb begin
    be_phase = PhIdle;
    be_time  = '0;
    be_cur   = sr_rem.bit_val;
    be_rem   = sr_rem.rem_next;
    be_rep   = rep_q;
    if (sr_rem.found) begin
      if ((sr_rem.bit_val ? one_low_q : zero_low_q) != 16'd0) begin
        be_phase = PhBitLow;
        be_time  = TimeW'(sr_rem.bit_val ? one_low_q : zero_low_q);
      end else begin
        be_phase = PhBitHigh;
        be_time  = TimeW'(sr_rem.bit_val ? one_high_q : zero_high_q);
      end
    end else if (footer_time_q != '0) begin
      be_phase = PhFooter;
      be_time  = footer_time_q;
    end else begin
      be_rep = rep_q - 8'd1;
      if (rep_q != 8'd1) begin
        be_phase = fs_phase;
        be_time  = fs_time;
        be_cur   = fs_cur;
        be_rem   = fs_rem;
      end
    end
  end

  always_comb begin
    phase_d     = phase_q;
    time_d      = time_q;
    rep_d       = rep_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    saved_msg_d = saved_msg_q;
    saved_len_d = saved_len_q;
    lvl         = 1'b0;
    busy        = 1'b0;
    done        = 1'b0;
    if (in_fire) begin
      if (is_start) begin
        if (phase_q == PhIdle) begin
          saved_msg_d = in_msg;
          saved_len_d = len_sat;
          rep_d       = repeat_count_q;
          if (repeat_count_q != 8'd0) begin
            phase_d = fs_phase;
            time_d  = fs_time;
            cur_d   = fs_cur;
            rem_d   = fs_rem;
          end
        end
        lvl  = (phase_d == PhIntro) || (phase_d == PhBitHigh);
        busy = (phase_d != PhIdle);
      end else if (phase_q != PhIdle) begin
        lvl  = (phase_q == PhIntro) || (phase_q == PhBitHigh);
        busy = 1'b1;
        if (time_q == TimeW'(1)) begin
          case (phase_q)
            PhIntro, PhBitHigh: begin
              phase_d = be_phase;
              time_d  = be_time;
              cur_d   = be_cur;
              rem_d   = be_rem;
              rep_d   = be_rep;
            end
            PhBitLow: begin
              if ((cur_q ? one_high_q : zero_high_q) != 16'd0) begin
                phase_d = PhBitHigh;
                time_d  = TimeW'(cur_q ? one_high_q : zero_high_q);
              end else begin
                phase_d = be_phase;
                time_d  = be_time;
                cur_d   = be_cur;
                rem_d   = be_rem;
                rep_d   = be_rep;
              end
            end
            PhFooter: begin
              rep_d = rep_q - 8'd1;
              if (rep_q != 8'd1) begin
                phase_d = fs_phase;
                time_d  = fs_time;
                cur_d   = fs_cur;
                rem_d   = fs_rem;
              end else begin
                phase_d = PhIdle;
                time_d  = '0;
              end
            end
            default: begin
              phase_d = PhIdle;
              time_d  = '0;
            end
          endcase
        end else begin
          time_d = time_q - TimeW'(1);
        end
        done = (phase_d == PhIdle);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_count_q <= '0;
      intro_time_q   <= '0;
      zero_low_q     <= '0;
      zero_high_q    <= '0;
      one_low_q      <= '0;
      one_high_q     <= '0;
      footer_time_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegRepeatCount:  repeat_count_q <= cfg_data_i[7:0];
        RegIntroTime:    intro_time_q   <= cfg_data_i[15:0];
        RegZeroLowTime:  zero_low_q     <= cfg_data_i[15:0];
        RegZeroHighTime: zero_high_q    <= cfg_data_i[15:0];
        RegOneLowTime:   one_low_q      <= cfg_data_i[15:0];
        RegOneHighTime:  one_high_q     <= cfg_data_i[15:0];
        RegFooterTime:   footer_time_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      time_q  <= '0;
      rep_q   <= '0;
    end else begin
      phase_q <= phase_d;
      time_q  <= time_d;
      rep_q   <= rep_d;
    end
  end

  // Message payload, only meaningful while busy
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    rem_q       <= rem_d;
    saved_msg_q <= saved_msg_d;
    saved_len_q <= saved_len_d;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {done, busy, lvl};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_data_q};

endmodule

// ----- rtl/pwook_checker.sv -----
module pwook_checker
  import pwook_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A finished transmission is reported on a busy tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
    else $error("done without busy");

  // The line is only driven high during a transmission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("line high while idle");

  // An empty result slot never blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result slot");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind pulse_width_ook_transmitter pwook_checker u_pwook_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
